// ----- design/mjssr_pkg.sv -----
// Shared types, constants and the angle-to-pulse conversion for the
// multi-joint servo slew ramp.
// No dependencies.
package mjssr_pkg;

	// Joint count and field widths
	localparam int JOINT_COUNT = 5;
	localparam int ANGLE_W     = 9;
	localparam int PULSE_W     = 9;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 9;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic [PULSE_W-1:0]        pulse_t;
	typedef logic [JOINT_COUNT-1:0]    joint_mask_t;
	typedef logic [CFG_INDEX_W-1:0]    cfg_index_t;

	// Register indexes: targets take 0..JOINT_COUNT-1, then the enable mask
	localparam cfg_index_t REG_TARGET_J0   = CFG_INDEX_W'(0);
	localparam cfg_index_t REG_ENABLE_MASK = CFG_INDEX_W'(JOINT_COUNT);

	// Servo travel and pulse limits
	localparam angle_t ANGLE_MIN = -9'sd135;
	localparam angle_t ANGLE_MAX = 9'sd135;
	localparam pulse_t PULSE_MIN = 9'd102;
	localparam pulse_t PULSE_MAX = 9'd510;

	// Span of the clamped angle measured from ANGLE_MIN (0..270)
	localparam logic [8:0] ANGLE_SPAN = 9'd270;

	// floor(y*408/270) = floor(y*68/45) = (y * 68 * 23302) >> 20, exact for y <= 270
	localparam int RECIP_SHIFT = 20;
	localparam logic [20:0] SCALE_MULT = 21'd1584536;

	// Reset angle of each joint (also the reset target)
	localparam angle_t RESET_ANGLE [JOINT_COUNT] = '{
		-9'sd120, -9'sd6, 9'sd0, 9'sd60, 9'sd0
	};

	// Clamp the angle, shift to 0..270 and scale onto the pulse range
	function automatic pulse_t pulse_of(input angle_t ang);
		logic [8:0]  y;
		logic [29:0] prod;
		logic [8:0]  scaled;
		if (ang < ANGLE_MIN) begin
			y = 9'd0;
		end else if (ang > ANGLE_MAX) begin
			y = ANGLE_SPAN;
		end else begin
			y = 9'(ang - ANGLE_MIN);
		end
		prod   = 30'(y) * 30'(SCALE_MULT);
		scaled = prod[RECIP_SHIFT +: 9];
		return scaled + PULSE_MIN;
	endfunction

endpackage

// ----- design/multi_joint_servo_slew_ramp_top.sv -----
// Top level of the multi-joint servo slew ramp: joint angle state, target and
// enable registers, and the registered pulse result.
// Depends on mjssr_pkg.

// Each transferred tick with step_tick high moves every enabled joint one degree
// toward its target; each tick returns the pulse counts of all five joints plus a moved flag.
// One tick is taken every clock cycle while in_stall is low; its result appears in the output
// register on the next cycle. The angle update and the pulse scaling (one
// constant multiply per joint) sit between the angle registers and the output
// register. in_stall is high only while a finished result is held by
// out_stall. Configuration writes are always ready; indexes past the enable
// mask are ignored. There is no clearing pass after reset.
module multi_joint_servo_slew_ramp_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// tick channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              step_tick,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mjssr_pkg::PULSE_W-1:0]     pulse_j0,
	output logic [mjssr_pkg::PULSE_W-1:0]     pulse_j1,
	output logic [mjssr_pkg::PULSE_W-1:0]     pulse_j2,
	output logic [mjssr_pkg::PULSE_W-1:0]     pulse_j3,
	output logic [mjssr_pkg::PULSE_W-1:0]     pulse_j4,
	output logic                              any_moved,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mjssr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mjssr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	mjssr_pkg::angle_t      angle_q  [mjssr_pkg::JOINT_COUNT];
	mjssr_pkg::angle_t      target_q [mjssr_pkg::JOINT_COUNT];
	mjssr_pkg::joint_mask_t enable_q;
	mjssr_pkg::angle_t      angle_nxt [mjssr_pkg::JOINT_COUNT];
	mjssr_pkg::joint_mask_t step_mask;
	mjssr_pkg::pulse_t      pulse_q  [mjssr_pkg::JOINT_COUNT];
	logic                   moved_q;
	logic                   out_valid_q;
	logic                   in_xfer;
	logic                   cfg_xfer;

	// Handshake
	assign in_stall  = out_valid_q & out_stall;
	assign in_xfer   = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;

	// Per-joint slew step
	always_comb begin
		for (int i = 0; i < mjssr_pkg::JOINT_COUNT; i++) begin
			angle_nxt[i] = angle_q[i];
			step_mask[i] = 1'b0;
			if (step_tick && enable_q[i]) begin
				if (angle_q[i] < target_q[i]) begin
					angle_nxt[i] = angle_q[i] + 9'sd1;
					step_mask[i] = 1'b1;
				end else if (angle_q[i] > target_q[i]) begin
					angle_nxt[i] = angle_q[i] - 9'sd1;
					step_mask[i] = 1'b1;
				end
			end
		end
	end

	// Joint angles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mjssr_pkg::JOINT_COUNT; i++) begin
				angle_q[i] <= mjssr_pkg::RESET_ANGLE[i];
			end
		end else if (in_xfer) begin
			for (int i = 0; i < mjssr_pkg::JOINT_COUNT; i++) begin
				angle_q[i] <= angle_nxt[i];
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mjssr_pkg::JOINT_COUNT; i++) begin
				target_q[i] <= mjssr_pkg::RESET_ANGLE[i];
			end
			enable_q <= '0;
		end else if (cfg_xfer) begin
			for (int i = 0; i < mjssr_pkg::JOINT_COUNT; i++) begin
				if (cfg_index == mjssr_pkg::REG_TARGET_J0 + mjssr_pkg::CFG_INDEX_W'(i)) begin
					target_q[i] <= mjssr_pkg::angle_t'(cfg_data);
				end
			end
			if (cfg_index == mjssr_pkg::REG_ENABLE_MASK) begin
				enable_q <= cfg_data[mjssr_pkg::JOINT_COUNT-1:0];
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			for (int i = 0; i < mjssr_pkg::JOINT_COUNT; i++) begin
				pulse_q[i] <= mjssr_pkg::pulse_of(angle_nxt[i]);
			end
			moved_q <= |step_mask;
		end
	end

	assign out_valid = out_valid_q;
	assign pulse_j0  = pulse_q[0];
	assign pulse_j1  = pulse_q[1];
	assign pulse_j2  = pulse_q[2];
	assign pulse_j3  = pulse_q[3];
	assign pulse_j4  = pulse_q[4];
	assign any_moved = moved_q;

endmodule

// ----- design/mjssr_checker.sv -----
// Port-level checks for the multi-joint servo slew ramp, bound to the top level.
// Depends on mjssr_pkg and multi_joint_servo_slew_ramp_top.
module mjssr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [mjssr_pkg::PULSE_W-1:0]     pulse_j0,
	input logic [mjssr_pkg::PULSE_W-1:0]     pulse_j4
);

	// A held result keeps its valid
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Every tick transfer produces a result on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("tick transfer gave no result");

	// Input side stalls exactly when a result is held
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output hold");

	// Pulse counts of joints 0 and 4 stay within the servo range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pulse_j0 >= mjssr_pkg::PULSE_MIN && pulse_j0 <= mjssr_pkg::PULSE_MAX
			&& pulse_j4 >= mjssr_pkg::PULSE_MIN && pulse_j4 <= mjssr_pkg::PULSE_MAX)
		else $error("pulse count out of range");

endmodule

bind multi_joint_servo_slew_ramp_top mjssr_checker u_mjssr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pulse_j0  (pulse_j0),
	.pulse_j4  (pulse_j4)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the multi-joint servo slew ramp: directed and random
// tick traffic, register settings between phases, and random idling on both sides.
// Depends on mjssr_pkg and multi_joint_servo_slew_ramp_top.
module tb_top;
	import mjssr_pkg::*;

	localparam int RANDOM_TICKS = 2000;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int FIRST_HOLD_AT = 400;
	localparam int HOLD_SPACING = 1100;
	localparam int MAX_REPORTS = 10;
	localparam int TIMEOUT = 12_000_000;

	// Unused register indexes past the enable mask
	localparam cfg_index_t IDX_SPARE_LO = cfg_index_t'(int'(REG_ENABLE_MASK) + 1);
	localparam cfg_index_t IDX_SPARE_HI = cfg_index_t'((1 << CFG_INDEX_W) - 1);

	// Receiver stall modes
	typedef enum logic [1:0] {
		RX_FLOW,
		RX_LIGHT,
		RX_HEAVY,
		RX_TOGGLE
	} rx_mode_t;

	// Pulse counts of all joints plus the moved flag
	typedef struct packed {
		pulse_t [JOINT_COUNT-1:0] pulse;
		logic                     moved;
	} servo_result_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       step_tick = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	pulse_t     pulse_j0, pulse_j1, pulse_j2, pulse_j3, pulse_j4;
	logic       any_moved;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	cfg_index_t cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Ticks waiting to be offered and results waiting to come back
	logic          tick_backlog [$];
	servo_result_t pending_results [$];

	// Predicted joint state and register copies
	angle_t      joint_deg [JOINT_COUNT];
	angle_t      goal_deg [JOINT_COUNT];
	joint_mask_t ramp_mask;

	int fail_count = 0;
	int results_checked = 0;
	int moved_results = 0;
	int low_ticks = 0;

	multi_joint_servo_slew_ramp_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.step_tick (step_tick),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pulse_j0  (pulse_j0),
		.pulse_j1  (pulse_j1),
		.pulse_j2  (pulse_j2),
		.pulse_j3  (pulse_j3),
		.pulse_j4  (pulse_j4),
		.any_moved (any_moved),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit
	initial begin
		#(TIMEOUT);
		$display("FAILURE");
		$finish;
	end

	// Clamp to servo travel, then scale linearly onto the pulse range
	function automatic pulse_t servo_pulse(input angle_t deg);
		int a, lo, hi;
		a  = deg;
		lo = int'(ANGLE_MIN);
		hi = int'(ANGLE_MAX);
		if (a < lo) a = lo;
		if (a > hi) a = hi;
		return pulse_t'((a - lo) * (int'(PULSE_MAX) - int'(PULSE_MIN)) / (hi - lo)
			+ int'(PULSE_MIN));
	endfunction

	// One tick: enabled joints step a degree toward their goal
	function automatic servo_result_t ramp_joints(input logic tick);
		servo_result_t r;
		r.moved = 1'b0;
		for (int j = 0; j < JOINT_COUNT; j++) begin
			if (tick && ramp_mask[j]) begin
				if (joint_deg[j] < goal_deg[j]) begin
					joint_deg[j] = joint_deg[j] + 1;
					r.moved = 1'b1;
				end else if (joint_deg[j] > goal_deg[j]) begin
					joint_deg[j] = joint_deg[j] - 1;
					r.moved = 1'b1;
				end
			end
			r.pulse[j] = servo_pulse(joint_deg[j]);
		end
		return r;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
	endtask

	// Idle: nothing queued, nothing offered, nothing in flight
	task automatic wait_idle();
		do @(negedge clk);
		while (tick_backlog.size() != 0 || in_valid || pending_results.size() != 0);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Tick driver: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin : tick_driver
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			step_tick  <= 1'b0;
			burst_left = $urandom_range(1, 40);
			gap_left   = 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left = gap_left - 1;
			end else if (tick_backlog.size() != 0) begin
				in_valid  <= 1'b1;
				step_tick <= tick_backlog.pop_front();
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: stall pattern by segments, plus long hold-offs
	always @(posedge clk or negedge arst_n) begin : result_receiver
		rx_mode_t mode;
		int seg_left;
		int hold_left;
		int taken;
		int next_hold;
		if (!arst_n) begin
			out_stall <= 1'b0;
			mode      = RX_FLOW;
			seg_left  = 0;
			hold_left = 0;
			taken     = 0;
			next_hold = FIRST_HOLD_AT;
		end else begin
			if (out_valid && !out_stall) taken++;
			if (hold_left == 0 && taken >= next_hold) begin
				hold_left = HOLD_OFF_CYCLES;
				next_hold = next_hold + HOLD_SPACING;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				if (seg_left == 0) begin
					mode     = rx_mode_t'($urandom_range(0, 3));
					seg_left = $urandom_range(10, 60);
				end
				seg_left--;
				case (mode)
					RX_FLOW:   out_stall <= 1'b0;
					RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
					RX_TOGGLE: out_stall <= !out_stall;
					default:   out_stall <= 1'b0;
				endcase
			end
		end
	end

	// Predict on tick transfers, track register writes, check result transfers
	always @(posedge clk) begin : scoreboard
		servo_result_t got, want;
		if (!arst_n) begin
			for (int j = 0; j < JOINT_COUNT; j++) begin
				joint_deg[j] = RESET_ANGLE[j];
				goal_deg[j]  = RESET_ANGLE[j];
			end
			ramp_mask = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < REG_ENABLE_MASK) begin
					goal_deg[cfg_index - REG_TARGET_J0] = angle_t'(cfg_data);
				end else if (cfg_index == REG_ENABLE_MASK) begin
					ramp_mask = cfg_data[JOINT_COUNT-1:0];
				end
			end
			if (out_valid && !out_stall) begin
				got.pulse = {pulse_j4, pulse_j3, pulse_j2, pulse_j1, pulse_j0};
				got.moved = any_moved;
				if (pending_results.size() == 0) begin
					note_failure($sformatf("result transfer with nothing pending (moved=%0b)",
						got.moved));
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					if (want.moved) moved_results++;
					for (int j = 0; j < JOINT_COUNT; j++) begin
						if (got.pulse[j] !== want.pulse[j])
							note_failure($sformatf("pulse_j%0d expected %0d got %0d",
								j, want.pulse[j], got.pulse[j]));
					end
					if (got.moved !== want.moved)
						note_failure($sformatf("any_moved expected %0b got %0b",
							want.moved, got.moved));
				end
			end
			if (in_valid && !in_stall) begin
				if (!step_tick) low_ticks++;
				pending_results.push_back(ramp_joints(step_tick));
			end
		end
	end

	// Stimulus: directed phases, then random register settings with tick runs
	initial begin : stimulus
		int ticks_issued;
		int run_len;
		int settings;
		logic [CFG_DATA_W-1:0] val;
		ticks_issued = 0;
		settings     = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings, nothing enabled: no joint moves, tick high and low
		tick_backlog.push_back(1'b1);
		tick_backlog.push_back(1'b0);
		tick_backlog.push_back(1'b1);
		wait_idle();

		// Travel limits and targets outside travel; mask with spare bits set
		write_reg(cfg_index_t'(REG_TARGET_J0 + 0), CFG_DATA_W'(ANGLE_MAX));
		write_reg(cfg_index_t'(REG_TARGET_J0 + 1), CFG_DATA_W'(ANGLE_MIN));
		write_reg(cfg_index_t'(REG_TARGET_J0 + 2), 9'h0FF);
		write_reg(cfg_index_t'(REG_TARGET_J0 + 3), 9'h100);
		write_reg(cfg_index_t'(REG_TARGET_J0 + 4), 9'h001);
		write_reg(REG_ENABLE_MASK, 9'h1FF);
		write_reg(IDX_SPARE_LO, 9'h1FF);
		write_reg(IDX_SPARE_HI, 9'h000);
		settings++;
		tick_backlog = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
		wait_idle();

		// Partial mask, upper data bits ignored
		write_reg(REG_ENABLE_MASK, 9'h1E5);
		settings++;
		tick_backlog = '{1'b1, 1'b1, 1'b1, 1'b1};
		wait_idle();

		// Mask cleared: ticks move nothing
		write_reg(REG_ENABLE_MASK, 9'h000);
		settings++;
		tick_backlog = '{1'b1, 1'b1};
		wait_idle();

		// Only a joint already at its target enabled
		write_reg(REG_ENABLE_MASK, 9'h010);
		settings++;
		tick_backlog = '{1'b1, 1'b1};
		wait_idle();

		// Random settings, each followed by a run of ticks
		while (ticks_issued < RANDOM_TICKS) begin
			for (int j = 0; j < JOINT_COUNT; j++) begin
				if ($urandom_range(0, 9) < 7) begin
					case ($urandom_range(0, 19))
						0: val = CFG_DATA_W'(ANGLE_MIN);
						1: val = CFG_DATA_W'(ANGLE_MAX);
						2: val = 9'h0FF;
						3: val = 9'h100;
						4, 5, 6, 7: val = CFG_DATA_W'($urandom);
						default: val = CFG_DATA_W'($urandom_range(0, 270) - 135);
					endcase
					write_reg(cfg_index_t'(REG_TARGET_J0 + j), val);
				end
			end
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 9))
					0, 1, 2: val = CFG_DATA_W'($urandom) | 9'h01F;
					3:       val = '0;
					default: val = CFG_DATA_W'($urandom);
				endcase
				write_reg(REG_ENABLE_MASK, val);
			end
			if ($urandom_range(0, 15) == 0)
				write_reg(cfg_index_t'($urandom_range(int'(IDX_SPARE_LO), int'(IDX_SPARE_HI))),
					CFG_DATA_W'($urandom));
			settings++;

			// Mostly short runs; some long enough to cross the full angle range
			run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(300, 420)
				: $urandom_range(20, 120);
			for (int k = 0; k < run_len; k++)
				tick_backlog.push_back($urandom_range(0, 9) != 0);
			ticks_issued += run_len;
			wait_idle();
		end

		repeat (8) @(posedge clk);
		$display("Run covered %0d step results (%0d on idle ticks, %0d with joint motion)",
			results_checked, low_ticks, moved_results);
		$display("across %0d register settings, with %0d failures seen", settings, fail_count);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- multi_joint_servo_slew_ramp_top.f -----
design/mjssr_pkg.sv
design/multi_joint_servo_slew_ramp_top.sv
design/mjssr_checker.sv
verif/tb_top.sv
